// ===== hdl/ivol_pkg.sv =====
// Shared types and constants for the streaming 3D integral volume block.
// No dependencies; imported by the top level and its checker.
package ivol_pkg;

    localparam int VOXEL_W    = 16;
    localparam int SUM_W      = 40;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = 11;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [VOXEL_W-1:0]    t_voxel;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [DIM_W-1:0]      t_dim;

    localparam t_cfg_idx CFG_VOL_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_VOL_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_VOL_DEPTH  = 2'd2;

    localparam t_cfg_data CFG_DIM_RESET = 9'd256;

    // Clamp a dimension register (0 acts as 1, above max acts as max), return dim - 1.
    function automatic t_dim dim_last(input t_cfg_data val, input t_dim max_dim);
        t_dim ext;
        t_dim dim;
        ext = DIM_W'(val);
        if (ext == '0) begin
            dim = DIM_W'(1);
        end else if (ext > max_dim) begin
            dim = max_dim;
        end else begin
            dim = ext;
        end
        return dim - DIM_W'(1);
    endfunction

endpackage

// ===== hdl/ivol_ram.sv =====
// Simple dual-port RAM: one write port, one read port with enabled, registered read data.
// No dependencies; used for the row store and the slice store.
module ivol_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/integral_volume_3d.sv =====
// Streaming 3D summed-volume table: top level with position counters, pipeline and stores.
// Depends on ivol_pkg and ivol_ram.
//
// Takes 16-bit voxels in raster order (x fastest, then y, then z) and returns, for each voxel,
// the 40-bit sum of all voxels at or before it on every axis, flagging the last voxel of the
// volume. Throughput is one voxel per clock unless the output stalls. A voxel is registered
// in stage one, where the reads of both stores return, then in the output register. The slice
// store holds MAX_WIDTH x MAX_HEIGHT sums (rounded up to powers of two) and needs no clearing
// after reset. The user writes dimensions through the configuration port between volumes, not
// enforced by the block. Zero acts as one and values above the MAX_ parameters are clamped.
module integral_volume_3d #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_DEPTH  = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ivol_pkg::t_cfg_idx  i_cfg_idx,
    input  ivol_pkg::t_cfg_data i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ivol_pkg::t_voxel    i_voxel_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ivol_pkg::t_sum      o_integral_sum,
    output logic               o_last_voxel
);
    import ivol_pkg::*;

    localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ZW = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1;
    localparam int RW = VOXEL_W + XW;
    localparam int PW = RW + YW;
    localparam int AW = XW + YW;

    t_cfg_data r_vol_width, r_vol_height, r_vol_depth;
    logic [XW-1:0] lim_x;
    logic [YW-1:0] lim_y;
    logic [ZW-1:0] lim_z;

    logic [XW-1:0] r_pos_x, n_pos_x;
    logic [YW-1:0] r_pos_y, n_pos_y;
    logic [ZW-1:0] r_pos_z, n_pos_z;
    logic          end_row, end_slice, end_vol;

    logic          in_xfer, s1_adv;
    logic          r_s1_valid;
    t_voxel        r_s1_value;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;
    logic          r_s1_y_nz, r_s1_z_nz, r_s1_last;

    logic [RW-1:0] r_row_sum, n_row_sum;
    logic [PW-1:0] above_rd, above, plane;
    t_sum          behind_rd, behind, total;

    logic          r_row_byp, r_slice_byp;
    logic [PW-1:0] r_row_byp_data;
    t_sum          r_slice_byp_data;

    logic          r_out_valid;
    t_sum          r_out_sum;
    logic          r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_width  <= CFG_DIM_RESET;
            r_vol_height <= CFG_DIM_RESET;
            r_vol_depth  <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOL_WIDTH:  r_vol_width  <= i_cfg_data;
                CFG_VOL_HEIGHT: r_vol_height <= i_cfg_data;
                CFG_VOL_DEPTH:  r_vol_depth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_x = XW'(dim_last(r_vol_width,  DIM_W'(MAX_WIDTH)));
    assign lim_y = YW'(dim_last(r_vol_height, DIM_W'(MAX_HEIGHT)));
    assign lim_z = ZW'(dim_last(r_vol_depth,  DIM_W'(MAX_DEPTH)));

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_s1_valid && !s1_adv);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        end_row   = r_pos_x >= lim_x;
        end_slice = end_row && (r_pos_y >= lim_y);
        end_vol   = end_slice && (r_pos_z >= lim_z);
        n_pos_x   = end_row   ? '0 : r_pos_x + XW'(1);
        n_pos_y   = r_pos_y;
        n_pos_z   = r_pos_z;
        if (end_row) begin
            n_pos_y = end_slice ? '0 : r_pos_y + YW'(1);
        end
        if (end_slice) begin
            n_pos_z = end_vol ? '0 : r_pos_z + ZW'(1);
        end
    end

    always_comb begin
        n_row_sum = ((r_s1_x == '0) ? '0 : r_row_sum) + RW'(r_s1_value);
        above     = r_row_byp   ? r_row_byp_data   : above_rd;
        behind    = r_slice_byp ? r_slice_byp_data : behind_rd;
        plane     = (r_s1_y_nz ? above : '0) + PW'(n_row_sum);
        total     = (r_s1_z_nz ? behind : '0) + SUM_W'(plane);
    end

    ivol_ram #(
        .WIDTH  (PW),
        .ADDR_W (XW)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_x),
        .i_wdata (plane),
        .i_re    (in_xfer),
        .i_raddr (r_pos_x),
        .o_rdata (above_rd)
    );

    ivol_ram #(
        .WIDTH  (SUM_W),
        .ADDR_W (AW)
    ) u_slice_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr ({r_s1_y, r_s1_x}),
        .i_wdata (total),
        .i_re    (in_xfer),
        .i_raddr ({r_pos_y, r_pos_x}),
        .o_rdata (behind_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_row_sum   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_pos_z <= n_pos_z;
            end
            if (s1_adv) begin
                r_row_sum <= n_row_sum;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // forward the write of the item leaving stage one to a read issued at the same edge
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_value       <= i_voxel_value;
            r_s1_x           <= r_pos_x;
            r_s1_y           <= r_pos_y;
            r_s1_y_nz        <= r_pos_y != '0;
            r_s1_z_nz        <= r_pos_z != '0;
            r_s1_last        <= end_vol;
            r_row_byp        <= s1_adv && (r_s1_x == r_pos_x);
            r_row_byp_data   <= plane;
            r_slice_byp      <= s1_adv && (r_s1_x == r_pos_x) && (r_s1_y == r_pos_y);
            r_slice_byp_data <= total;
        end
        if (s1_adv) begin
            r_out_sum  <= total;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_integral_sum = r_out_sum;
    assign o_last_voxel   = r_out_last;

endmodule

// ===== hdl/ivol_checker.sv =====
// Port-level checker for integral_volume_3d, bound to the top level below.
// Depends on ivol_pkg.
module ivol_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ivol_pkg::t_sum o_integral_sum,
    input logic           o_last_voxel
);
    import ivol_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_integral_sum) && $stable(o_last_voxel))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !i_rst_n || (o_out_valid && i_out_stall))
        else $error("input stalled while output side can drain");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid ##1 !o_out_valid |=> o_out_valid)
        else $error("transferred voxel produced no result");

endmodule

bind integral_volume_3d ivol_checker u_ivol_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_integral_sum (o_integral_sum),
    .o_last_voxel   (o_last_voxel)
);

// ===== bench/tb_integral_volume_3d.sv =====
// Testbench for integral_volume_3d: streams voxel volumes through the block and
// checks every 3D integral sum and end-of-volume flag against an in-bench predictor.
// Depends on ivol_pkg and the integral_volume_3d RTL.
module tb_integral_volume_3d;
    timeunit 1ns;
    timeprecision 1ps;

    import ivol_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int MAX_D       = 256;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_sum integral_sum;
        logic last_voxel;
    } t_expect;

    logic      clk;
    logic      rst_n    = 1'b0;
    logic      cfg_we   = 1'b0;
    t_cfg_idx  cfg_idx  = CFG_VOL_WIDTH;
    t_cfg_data cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_voxel    voxel    = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_sum      integral_sum;
    logic      last_voxel;

    t_voxel  pending_voxels[$];
    t_expect expected_sums[$];

    logic tx_burst  = 1'b0;
    logic rx_burst  = 1'b0;
    logic hold_go   = 1'b0;
    int   tx_gap    = 0;
    int   rx_wait   = 0;
    int   rx_hold   = 0;
    int   err_count = 0;
    int   cycle_count = 0;

    // predictor state
    t_sum        slice_sums [MAX_W*MAX_H];
    logic [31:0] row_plane  [MAX_W];
    logic [23:0] row_acc    = '0;
    int unsigned pos_x = 0, pos_y = 0, pos_z = 0;
    t_cfg_data   reg_width  = CFG_DIM_RESET;
    t_cfg_data   reg_height = CFG_DIM_RESET;
    t_cfg_data   reg_depth  = CFG_DIM_RESET;

    integral_volume_3d #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H),
        .MAX_DEPTH (MAX_D)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_voxel_value (voxel),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_integral_sum(integral_sum),
        .o_last_voxel  (last_voxel)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int unsigned clamp_dim(input t_cfg_data val, input int unsigned max_dim);
        if (val == '0) return 1;
        if (val > max_dim) return max_dim;
        return val;
    endfunction

    function automatic void integrate_voxel(input t_voxel v);
        int unsigned w, h, d, x, y, slot;
        logic [31:0] above, plane;
        t_sum        behind, total;
        logic        end_row, end_slice, end_vol;
        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, MAX_H);
        d = clamp_dim(reg_depth, MAX_D);
        x = pos_x % MAX_W;
        y = pos_y % MAX_H;
        slot = y * MAX_W + x;
        if (x == 0) row_acc = '0;
        row_acc = row_acc + 24'(v);
        above = (y != 0) ? row_plane[x] : '0;
        plane = above + 32'(row_acc);
        row_plane[x] = plane;
        behind = (pos_z != 0) ? slice_sums[slot] : '0;
        total = behind + SUM_W'(plane);
        slice_sums[slot] = total;
        end_row   = (pos_x >= w - 1);
        end_slice = end_row && (pos_y >= h - 1);
        end_vol   = end_slice && (pos_z >= d - 1);
        expected_sums.push_back(t_expect'{integral_sum: total, last_voxel: end_vol});
        if (!end_row) begin
            pos_x++;
        end else begin
            pos_x = 0;
            if (!end_slice) begin
                pos_y++;
            end else begin
                pos_y = 0;
                pos_z = end_vol ? 0 : pos_z + 1;
            end
        end
    endfunction

    // driver
    always @(posedge clk) begin
        logic fire;
        fire = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (fire) integrate_voxel(voxel);
            if (!in_valid || fire) begin
                if (tx_gap > 0) begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end else if (pending_voxels.size() > 0) begin
                    in_valid <= 1'b1;
                    voxel    <= pending_voxels.pop_front();
                    tx_gap   <= tx_burst ? 0 : $urandom_range(0, 19);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_expect exp_r;
        int      w;
        int      h;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
            rx_hold   <= 0;
        end else begin
            w = rx_wait;
            h = rx_hold;
            if (out_valid && !out_stall) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected transfer: integral_sum %0d last_voxel %0b",
                           integral_sum, last_voxel);
                    err_count++;
                end else begin
                    exp_r = expected_sums.pop_front();
                    if (integral_sum !== exp_r.integral_sum) begin
                        $error("integral_sum: expected %0d, got %0d",
                               exp_r.integral_sum, integral_sum);
                        err_count++;
                    end
                    if (last_voxel !== exp_r.last_voxel) begin
                        $error("last_voxel: expected %0b, got %0b",
                               exp_r.last_voxel, last_voxel);
                        err_count++;
                    end
                end
                w = rx_burst ? 0 : $urandom_range(0, 19);
            end else if (w > 0) begin
                w--;
            end
            if (hold_go) h = HOLD_CYCLES;
            else if (h > 0) h--;
            rx_wait   <= w;
            rx_hold   <= h;
            out_stall <= (w > 0) || (h > 0);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integral_volume_3d: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_VOL_WIDTH:  reg_width  = val;
            CFG_VOL_HEIGHT: reg_height = val;
            CFG_VOL_DEPTH:  reg_depth  = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input t_cfg_data w, input t_cfg_data h, input t_cfg_data d);
        write_reg(CFG_VOL_WIDTH, w);
        write_reg(CFG_VOL_HEIGHT, h);
        write_reg(CFG_VOL_DEPTH, d);
    endtask

    task automatic drain();
        while (pending_voxels.size() != 0 || in_valid || expected_sums.size() != 0)
            @(negedge clk);
    endtask

    function automatic t_cfg_data dim_code(input int unsigned eff);
        if (eff == 1 && $urandom_range(0, 1) == 1) return '0;
        if (eff == 256 && $urandom_range(0, 1) == 1) return t_cfg_data'($urandom_range(257, 511));
        return t_cfg_data'(eff);
    endfunction

    function automatic t_voxel draw_voxel(input int kind);
        case (kind)
            0:       return t_voxel'($urandom);
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2:       return t_voxel'($urandom_range(0, 15));
            default: return t_voxel'($urandom_range(16'hFF00, 16'hFFFF));
        endcase
    endfunction

    task automatic push_voxels(input int count, input int kind);
        @(negedge clk);
        repeat (count) pending_voxels.push_back(draw_voxel(kind));
    endtask

    initial begin
        t_voxel      first_vol[12];
        int unsigned ew, eh, ed, vol_size, nvol;
        int          random_count;
        int          phase;

        first_vol = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                      16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'hFFFF};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: full-scale and zero voxels over first row and first slice
        set_dims(9'd3, 9'd2, 9'd2);
        @(negedge clk);
        foreach (first_vol[i]) pending_voxels.push_back(first_vol[i]);
        drain();

        // unknown index is ignored; zero dimensions act as one
        write_reg(CFG_UNUSED, 9'h1FF);
        set_dims(9'd0, 9'd0, 9'd0);
        @(negedge clk);
        pending_voxels.push_back(16'hFFFF);
        pending_voxels.push_back(16'h0000);
        drain();

        // shrink depth in mid-volume: the current slice becomes the last
        set_dims(9'd2, 9'd2, 9'd3);
        push_voxels(6, 0);
        drain();
        write_reg(CFG_VOL_DEPTH, 9'd1);
        push_voxels(2, 0);
        push_voxels(4, 1);
        drain();

        random_count = 0;
        phase = 0;
        while (random_count < RANDOM_ITEMS) begin
            drain();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            case (phase)
                0: begin
                    ew = 256; eh = 1; ed = 1;
                    tx_burst = 1'b1;
                end
                1: begin
                    ew = 1; eh = 256; ed = 1;
                end
                2: begin
                    ew = 1; eh = 1; ed = 256;
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        ew = $urandom_range(100, 256);
                        eh = $urandom_range(1, 2);
                        ed = 1;
                    end else begin
                        ew = $urandom_range(1, 12);
                        eh = $urandom_range(1, 6);
                        ed = $urandom_range(1, 5);
                    end
                end
            endcase
            set_dims(dim_code(ew), dim_code(eh), dim_code(ed));
            vol_size = ew * eh * ed;
            nvol = (vol_size > 64) ? 1 : $urandom_range(1, 3);
            repeat (nvol) push_voxels(vol_size, $urandom_range(0, 3));
            if (phase == 0) begin
                // hold the output while the sender keeps offering voxels
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            random_count += nvol * vol_size;
            phase++;
        end

        drain();
        repeat (10) @(negedge clk);
        if (err_count == 0) begin
            $display("integral_volume_3d: match");
        end else begin
            $display("integral_volume_3d: mismatch");
        end
        $finish;
    end

endmodule
